FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SLPS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SLPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/slps_pkg.sv
`default_nettype none
package slps_pkg;

  typedef enum logic [2:0] {
    MODE_BOOT  = 3'd0,
    MODE_IDLE  = 3'd1,
    MODE_RX    = 3'd2,
    MODE_ERROR = 3'd3,
    MODE_OFF   = 3'd4
  } mode_t;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_MODE  = 2'd1;
  localparam logic [1:0] FUNC_FORCE = 2'd2;

  localparam logic [2:0] REG_BOOT_HALF    = 3'd0;
  localparam logic [2:0] REG_BREATH_STEP  = 3'd1;
  localparam logic [2:0] REG_RX_HALF      = 3'd2;
  localparam logic [2:0] REG_RX_TIMEOUT   = 3'd3;
  localparam logic [2:0] REG_BOOT_LEVEL   = 3'd4;
  localparam logic [2:0] REG_RX_LEVEL     = 3'd5;
  localparam logic [2:0] REG_BREATH_FLOOR = 3'd6;
  localparam logic [2:0] REG_BREATH_PEAK  = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic [15:0] boot_half;
    logic [15:0] breath_step;
    logic [15:0] rx_half;
    logic [15:0] rx_timeout;
    logic [7:0]  boot_level;
    logic [7:0]  rx_level;
    logic [7:0]  breath_floor;
    logic [7:0]  breath_peak;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    mode_t       restore_mode;
    logic        forced;
    logic [15:0] phase_ticks;
    logic [8:0]  breath_index;
    logic        half_select;
    logic [15:0] rx_elapsed;
    color_t      color;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    boot_half:    16'd100,
    breath_step:  16'd200,
    rx_half:      16'd50,
    rx_timeout:   16'd200,
    boot_level:   8'd20,
    rx_level:     8'd50,
    breath_floor: 8'd2,
    breath_peak:  8'd10
  };

  localparam state_t STATE_RESET = '{
    mode:         MODE_BOOT,
    restore_mode: MODE_IDLE,
    forced:       1'b0,
    phase_ticks:  16'd0,
    breath_index: 9'd0,
    half_select:  1'b0,
    rx_elapsed:   16'd0,
    color:        24'd0
  };

endpackage
`default_nettype wire

FILE: sv/status_led_pattern_sequencer.sv
// Status LED pattern sequencer: one word per clock in while m_tready does not
// stall the output, one result word per input word out; each accepted word
// passes the input register, then the state update into the result register.
// s_tuser carries the function (tick, mode request, forced-off request); every
// input word yields exactly one result word with the LED color, the current
// mode and the forced-off flag. Configuration writes take effect from the next
// word and do not repaint the LED; write them only while no word is in flight.
`default_nettype none
`include "assert_macros.svh"
module status_led_pattern_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [2:0] new_mode, [3] off_request, [7:4] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                      // [26:24] shown_mode, [27] is_forced_off, [31:28] zero
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import slps_pkg::*;

  cfg_t        cfg;
  state_t      st;
  state_t      st_next;
  logic        in_valid;
  logic [1:0]  in_func;
  logic [2:0]  in_new_mode;
  logic        in_off;
  logic        out_valid;
  logic        advance;
  color_t      out_color;
  mode_t       out_mode;
  logic        out_forced;

  slps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slps_step u_step (
    .cur         (st),
    .cfg         (cfg),
    .func        (in_func),
    .new_mode    (in_new_mode),
    .off_request (in_off),
    .nxt         (st_next)
  );

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_forced, out_mode, out_color.blue, out_color.green,
                     out_color.red};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= STATE_RESET;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func     <= s_tuser;
      in_new_mode <= s_tdata[2:0];
      in_off      <= s_tdata[3];
    end
    if (advance) begin
      out_color  <= st_next.color;
      out_mode   <= st_next.mode;
      out_forced <= st_next.forced;
    end
  end

  `SLPS_ASSERT_IMPLIES(a_forced_is_off, st.forced, st.mode == MODE_OFF, "forced without off mode")
  `SLPS_ASSERT_IMPLIES(a_off_is_black, st.mode == MODE_OFF, st.color == '0, "off mode not black")
  `SLPS_ASSERT_IMPLIES(a_half_mode, st.half_select,
    st.mode == MODE_BOOT || st.mode == MODE_RX, "half select in non-blink mode")
  `SLPS_ASSERT_NEXT(a_adv_result, advance, out_valid, "result lost after update")

endmodule
`default_nettype wire

FILE: sv/slps_cfg_regs.sv
`default_nettype none
module slps_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  output slps_pkg::cfg_t     cfg
);
  import slps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOOT_HALF:    cfg.boot_half    <= cfg_data;
        REG_BREATH_STEP:  cfg.breath_step  <= cfg_data;
        REG_RX_HALF:      cfg.rx_half      <= cfg_data;
        REG_RX_TIMEOUT:   cfg.rx_timeout   <= cfg_data;
        REG_BOOT_LEVEL:   cfg.boot_level   <= cfg_data[7:0];
        REG_RX_LEVEL:     cfg.rx_level     <= cfg_data[7:0];
        REG_BREATH_FLOOR: cfg.breath_floor <= cfg_data[7:0];
        REG_BREATH_PEAK:  cfg.breath_peak  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/slps_step.sv
`default_nettype none
module slps_step (
  input  wire slps_pkg::state_t cur,
  input  wire slps_pkg::cfg_t   cfg,
  input  wire logic [1:0]       func,
  input  wire logic [2:0]       new_mode,
  input  wire logic             off_request,
  output slps_pkg::state_t      nxt
);
  import slps_pkg::*;

  logic [7:0]  peak;
  logic [8:0]  span;
  logic [9:0]  breath_len;
  logic [15:0] half_len;
  logic [15:0] step_len;
  logic [15:0] pt_inc;
  logic        wrap;
  logic [9:0]  bidx_inc;
  logic [7:0]  lvl;
  logic        set_req;
  mode_t       set_mode;
  logic        repaint;

  // breathing ramp
  always_comb begin
    peak       = (cfg.breath_peak < cfg.breath_floor) ? cfg.breath_floor : cfg.breath_peak;
    span       = {1'b0, peak} - {1'b0, cfg.breath_floor} + 9'd1;
    breath_len = {span, 1'b0};
  end

  // phase counter for the current pattern
  always_comb begin
    case (cur.mode)
      MODE_IDLE: half_len = cfg.breath_step;
      MODE_RX:   half_len = cfg.rx_half;
      default:   half_len = cfg.boot_half;
    endcase
    step_len = (half_len == 16'd0) ? 16'd1 : half_len;
    pt_inc   = cur.phase_ticks + 16'd1;
    wrap     = (pt_inc >= step_len);
    bidx_inc = {1'b0, cur.breath_index} + 10'd1;
  end

  always_comb begin
    nxt      = cur;
    set_req  = 1'b0;
    set_mode = cur.mode;
    repaint  = 1'b0;
    lvl      = cfg.breath_floor;
    case (func)
      FUNC_TICK: begin
        repaint = 1'b1;
        if (cur.rx_elapsed != 16'hFFFF) nxt.rx_elapsed = cur.rx_elapsed + 16'd1;
        case (cur.mode)
          MODE_BOOT: begin
            nxt.phase_ticks = wrap ? 16'd0 : pt_inc;
            if (wrap) nxt.half_select = ~cur.half_select;
          end
          MODE_IDLE: begin
            nxt.phase_ticks = wrap ? 16'd0 : pt_inc;
            if (wrap) nxt.breath_index = (bidx_inc >= breath_len) ? 9'd0 : bidx_inc[8:0];
          end
          MODE_RX: begin
            nxt.phase_ticks = wrap ? 16'd0 : pt_inc;
            if (wrap) begin
              nxt.half_select = ~cur.half_select;
              // end of the off half: time out to idle
              if (cur.half_select && nxt.rx_elapsed > cfg.rx_timeout) begin
                set_req  = 1'b1;
                set_mode = MODE_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      FUNC_MODE: begin
        if (new_mode <= MODE_OFF) begin
          if (new_mode == MODE_RX) nxt.rx_elapsed = 16'd0;
          if (cur.forced) begin
            nxt.restore_mode = mode_t'(new_mode);
          end else begin
            set_req  = 1'b1;
            set_mode = mode_t'(new_mode);
          end
        end
      end
      FUNC_FORCE: begin
        set_req = 1'b1;
        if (off_request) begin
          nxt.restore_mode = cur.mode;
          nxt.forced       = 1'b1;
          set_mode         = MODE_OFF;
        end else begin
          nxt.forced = 1'b0;
          set_mode   = cur.restore_mode;
        end
      end
      default: ;
    endcase

    if (set_req) begin
      repaint = 1'b0;
      if (set_mode != cur.mode) begin
        nxt.mode         = set_mode;
        nxt.phase_ticks  = 16'd0;
        nxt.breath_index = 9'd0;
        nxt.half_select  = 1'b0;
        repaint          = 1'b1;
      end
    end

    if (repaint) begin
      case (nxt.mode)
        MODE_BOOT: begin
          nxt.color      = '0;
          nxt.color.blue = nxt.half_select ? 8'd0 : cfg.boot_level;
        end
        MODE_IDLE: begin
          if (nxt.breath_index < span) begin
            lvl = cfg.breath_floor + nxt.breath_index[7:0];
          end else if ({1'b0, nxt.breath_index} < breath_len) begin
            lvl = peak - 8'(nxt.breath_index - span);
          end
          nxt.color.red   = lvl;
          nxt.color.green = 8'd0;
          nxt.color.blue  = lvl;
        end
        MODE_RX: begin
          nxt.color       = '0;
          nxt.color.green = nxt.half_select ? 8'd0 : cfg.rx_level;
        end
        MODE_OFF: nxt.color = '0;
        default: ;  // error holds the color
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb_status_led_pattern_sequencer.sv
module tb_status_led_pattern_sequencer;
  import slps_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;  // unused code, must change nothing
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    mode_t      mode;
    logic       forced;
  } led_word_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [2:0] new_mode, [3] off_request, [7:4] zero
  logic [1:0]  s_tuser;   // [1:0] func
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [7:0] red, [15:8] green, [23:16] blue, [26:24] mode, [27] forced
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  status_led_pattern_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // shadow of the sequencer
  cfg_t        cfg;
  mode_t       cur_mode;
  mode_t       saved_mode;
  logic        forced_off;
  logic [15:0] phase_cnt;
  logic [8:0]  breath_pos;
  logic        off_half;
  logic [15:0] rx_age;
  color_t      led;

  led_word_t expected_leds[$];
  led_word_t want;

  int  n_words = 0;
  int  n_results = 0;
  int  n_errors = 0;
  int  n_rx_timeouts = 0;
  int  n_settings = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;

  function automatic int breath_len();
    int pk;
    pk = int'((cfg.breath_peak < cfg.breath_floor) ? cfg.breath_floor : cfg.breath_peak);
    return 2 * (pk - int'(cfg.breath_floor) + 1);
  endfunction

  function automatic void repaint();
    int pk, n, i, lvl;
    case (cur_mode)
      MODE_BOOT: begin
        led = '0;
        if (!off_half) led.blue = cfg.boot_level;
      end
      MODE_IDLE: begin
        pk = int'((cfg.breath_peak < cfg.breath_floor) ? cfg.breath_floor : cfg.breath_peak);
        n = pk - int'(cfg.breath_floor) + 1;
        i = int'(breath_pos);
        if (i < n) lvl = int'(cfg.breath_floor) + i;
        else if (i < 2 * n) lvl = pk - (i - n);
        else lvl = int'(cfg.breath_floor);
        led.red = lvl[7:0];
        led.green = 8'd0;
        led.blue = lvl[7:0];
      end
      MODE_RX: begin
        led = '0;
        if (!off_half) led.green = cfg.rx_level;
      end
      MODE_OFF: led = '0;
      default: ;  // error holds the color
    endcase
  endfunction

  function automatic void enter_mode(mode_t m);
    if (m == cur_mode) return;
    cur_mode = m;
    phase_cnt = 16'd0;
    breath_pos = 9'd0;
    off_half = 1'b0;
    repaint();
  endfunction

  function automatic bit phase_done(int len);
    if (len == 0) len = 1;
    phase_cnt = phase_cnt + 16'd1;
    if (int'(phase_cnt) >= len) begin
      phase_cnt = 16'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void tick_pattern();
    int next_pos;
    if (rx_age != 16'hFFFF) rx_age = rx_age + 16'd1;
    case (cur_mode)
      MODE_BOOT: if (phase_done(int'(cfg.boot_half))) off_half = ~off_half;
      MODE_IDLE: begin
        if (phase_done(int'(cfg.breath_step))) begin
          next_pos = int'(breath_pos) + 1;
          breath_pos = (next_pos >= breath_len()) ? 9'd0 : next_pos[8:0];
        end
      end
      MODE_RX: begin
        if (phase_done(int'(cfg.rx_half))) begin
          off_half = ~off_half;
          if (!off_half && rx_age > cfg.rx_timeout) begin
            n_rx_timeouts++;
            enter_mode(MODE_IDLE);
            return;
          end
        end
      end
      default: ;
    endcase
    repaint();
  endfunction

  function automatic void reset_shadow();
    cfg = CFG_RESET;
    cur_mode = MODE_BOOT;
    saved_mode = MODE_IDLE;
    forced_off = 1'b0;
    phase_cnt = 16'd0;
    breath_pos = 9'd0;
    off_half = 1'b0;
    rx_age = 16'd0;
    led = '0;
  endfunction

  function automatic void predict_led(logic [1:0] fn, logic [2:0] nm, logic off);
    led_word_t w;
    case (fn)
      FUNC_TICK: tick_pattern();
      FUNC_MODE: begin
        if (nm <= MODE_OFF) begin
          if (nm == MODE_RX) rx_age = 16'd0;
          if (forced_off) saved_mode = mode_t'(nm);
          else enter_mode(mode_t'(nm));
        end
      end
      FUNC_FORCE: begin
        if (off) begin
          saved_mode = cur_mode;
          forced_off = 1'b1;
          enter_mode(MODE_OFF);
        end else begin
          forced_off = 1'b0;
          enter_mode(saved_mode);
        end
      end
      default: ;
    endcase
    w.red = led.red;
    w.green = led.green;
    w.blue = led.blue;
    w.mode = cur_mode;
    w.forced = forced_off;
    expected_leds.push_back(w);
  endfunction

  function automatic void check_field(string what, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, act_v);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_leds.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, m_tdata);
        n_errors++;
      end else begin
        want = expected_leds.pop_front();
        n_results++;
        check_field("red", int'(want.red), int'(m_tdata[7:0]));
        check_field("green", int'(want.green), int'(m_tdata[15:8]));
        check_field("blue", int'(want.blue), int'(m_tdata[23:16]));
        check_field("shown_mode", int'(want.mode), int'(m_tdata[26:24]));
        check_field("is_forced_off", int'(want.forced), int'(m_tdata[27]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, %0d results outstanding", $time, expected_leds.size());
        $display("tb_status_led_pattern_sequencer: done, errors");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_word(logic [1:0] fn, logic [2:0] nm, logic off);
    int gap;
    if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser = fn;
    s_tdata = {4'b0000, off, nm};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_led(fn, nm, off);
    n_words++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_leds.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      REG_BOOT_HALF:    cfg.boot_half = val;
      REG_BREATH_STEP:  cfg.breath_step = val;
      REG_RX_HALF:      cfg.rx_half = val;
      REG_RX_TIMEOUT:   cfg.rx_timeout = val;
      REG_BOOT_LEVEL:   cfg.boot_level = val[7:0];
      REG_RX_LEVEL:     cfg.rx_level = val[7:0];
      REG_BREATH_FLOOR: cfg.breath_floor = val[7:0];
      REG_BREATH_PEAK:  cfg.breath_peak = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_settings(cfg_t c);
    wait_idle();
    write_reg(REG_BOOT_HALF, c.boot_half);
    write_reg(REG_BREATH_STEP, c.breath_step);
    write_reg(REG_RX_HALF, c.rx_half);
    write_reg(REG_RX_TIMEOUT, c.rx_timeout);
    write_reg(REG_BOOT_LEVEL, {8'd0, c.boot_level});
    write_reg(REG_RX_LEVEL, {8'd0, c.rx_level});
    write_reg(REG_BREATH_FLOOR, {8'd0, c.breath_floor});
    write_reg(REG_BREATH_PEAK, {8'd0, c.breath_peak});
    n_settings++;
  endtask

  task automatic send_random_word();
    int r;
    logic [2:0] nm;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      send_word(FUNC_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end else if (r < 85) begin
      nm = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_word(FUNC_MODE, nm, 1'($urandom_range(0, 1)));
    end else if (r < 96) begin
      send_word(FUNC_FORCE, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end else begin
      send_word(FUNC_NONE, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end
  endtask

  // every function and mode, unknown codes, forced-off corner cases
  task automatic test_directed();
    send_word(FUNC_TICK, 3'd0, 1'b0);
    send_word(FUNC_NONE, 3'd7, 1'b1);
    send_word(FUNC_MODE, 3'd5, 1'b0);
    send_word(FUNC_MODE, 3'd7, 1'b1);
    send_word(FUNC_MODE, MODE_BOOT, 1'b0);
    send_word(FUNC_MODE, MODE_IDLE, 1'b0);
    send_word(FUNC_MODE, MODE_IDLE, 1'b0);
    send_word(FUNC_TICK, 3'd7, 1'b1);
    send_word(FUNC_MODE, MODE_RX, 1'b0);
    send_word(FUNC_TICK, 3'd0, 1'b0);
    send_word(FUNC_MODE, MODE_ERROR, 1'b0);
    send_word(FUNC_TICK, 3'd0, 1'b0);
    send_word(FUNC_MODE, MODE_OFF, 1'b0);
    send_word(FUNC_TICK, 3'd0, 1'b0);
    send_word(FUNC_FORCE, 3'd0, 1'b0);   // release while not forced
    send_word(FUNC_FORCE, 3'd7, 1'b1);
    send_word(FUNC_FORCE, 3'd0, 1'b1);   // second force saves off
    send_word(FUNC_MODE, MODE_RX, 1'b0);
    send_word(FUNC_MODE, 3'd6, 1'b0);
    send_word(FUNC_TICK, 3'd0, 1'b0);
    send_word(FUNC_FORCE, 3'd0, 1'b0);
    send_word(FUNC_TICK, 3'd0, 1'b0);
    send_word(FUNC_MODE, MODE_BOOT, 1'b0);
    send_word(FUNC_TICK, 3'd0, 1'b0);
  endtask

  // shrink the breathing range while the index sits past its new end
  task automatic test_breath_index_overrun();
    cfg_t c;
    c = cfg;
    c.breath_step = 16'd1;
    c.breath_floor = 8'd0;
    c.breath_peak = 8'd20;
    apply_settings(c);
    send_word(FUNC_MODE, MODE_IDLE, 1'b0);
    repeat (30) send_word(FUNC_TICK, 3'd0, 1'b0);
    c.breath_peak = 8'd3;
    apply_settings(c);
    repeat (6) send_word(FUNC_TICK, 3'd0, 1'b0);
  endtask

  task automatic test_random_settings();
    cfg_t c;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: c = CFG_RESET;
        1: c = '{boot_half: 16'd1, breath_step: 16'd1, rx_half: 16'd1, rx_timeout: 16'd0,
                 boot_level: 8'd255, rx_level: 8'd255, breath_floor: 8'd0,
                 breath_peak: 8'd255};
        2: c = '{boot_half: 16'd65535, breath_step: 16'd65535, rx_half: 16'd65535,
                 rx_timeout: 16'd65534, boot_level: 8'd0, rx_level: 8'd0,
                 breath_floor: 8'd255, breath_peak: 8'd0};
        3: c = '{boot_half: 16'd0, breath_step: 16'd0, rx_half: 16'd0, rx_timeout: 16'd3,
                 boot_level: 8'd128, rx_level: 8'd127, breath_floor: 8'd128,
                 breath_peak: 8'd128};
        default: begin
          c.boot_half = 16'($urandom_range(1, 6));
          c.breath_step = 16'($urandom_range(1, 4));
          c.rx_half = 16'($urandom_range(1, 5));
          c.rx_timeout = 16'($urandom_range(0, 30));
          c.boot_level = 8'($urandom_range(0, 255));
          c.rx_level = 8'($urandom_range(0, 255));
          c.breath_floor = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 2) == 0) c.breath_peak = 8'($urandom_range(0, 255));
          else c.breath_peak = (c.breath_floor > 8'd243) ? 8'd255 :
                               c.breath_floor + 8'($urandom_range(0, 12));
        end
      endcase
      apply_settings(c);
      repeat (185) send_random_word();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    s_tuser = FUNC_TICK;
    cfg_we = 1'b0;
    cfg_index = REG_BOOT_HALF;
    cfg_data = 16'd0;
    reset_shadow();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_breath_index_overrun();
    test_random_settings();

    wait_idle();
    $display("words sent %0d, results compared %0d, receive timeouts %0d",
             n_words, n_results, n_rx_timeouts);
    $display("register settings applied %0d, mismatches %0d", n_settings, n_errors);
    if (n_errors == 0) begin
      $display("tb_status_led_pattern_sequencer: done, clean");
    end else begin
      $display("tb_status_led_pattern_sequencer: done, errors");
    end
    $finish;
  end

endmodule
